// ===== hw/rtl/assert_macros.svh =====
// Assertion macros shared by the checker modules.
// Needs a signal named clock and one named reset where they are used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked only outside reset
`define SRL_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// checked at every edge, reset included
`define SRL_ASSERT_ALWAYS(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) prop) else $error(msg);

`endif

// ===== hw/rtl/srl_pkg.sv =====
// Types, constants and helper functions of the S-record stream loader.
// No dependencies; used by s_record_stream_loader and its checker.
`default_nettype none

package srl_pkg;

   localparam int LINE_LIMIT = 253;
   localparam int POS_W      = $clog2(LINE_LIMIT + 1);

   // line modes
   localparam logic [1:0] MODE_START  = 2'd0;
   localparam logic [1:0] MODE_ACTIVE = 2'd1;
   localparam logic [1:0] MODE_SKIP   = 2'd2;

   // request kinds (req_tuser)
   localparam logic CMD_CHAR = 1'b0;
   localparam logic CMD_END  = 1'b1;

   // response kinds (rsp_tuser)
   localparam logic KIND_WRITE  = 1'b0;
   localparam logic KIND_REPORT = 1'b1;

   // load status
   localparam logic [1:0] STATUS_OK       = 2'd0;
   localparam logic [1:0] STATUS_BAD_LINE = 2'd1;
   localparam logic [1:0] STATUS_BAD_TYPE = 2'd2;

   localparam logic [7:0] CH_S  = 8'h53;
   localparam logic [7:0] CH_NL = 8'h0a;

   // response tdata layout, lowest bit first
   localparam int RSP_ADDR_LO   = 0;
   localparam int RSP_MASK_LO   = 30;
   localparam int RSP_DATA_LO   = 34;
   localparam int RSP_STATUS_LO = 66;
   localparam int RSP_START_LO  = 68;
   localparam int RSP_BITS      = 100;
   localparam int RSP_TDATA_W   = ((RSP_BITS + 7) / 8) * 8;

   typedef struct packed {
      logic [31:0] start_address;
      logic [1:0]  status;
      logic [31:0] write_data;
      logic [3:0]  byte_mask;
      logic [29:0] word_address;
   } rsp_fields_type;

   // bit 4 set: not a hex digit
   function automatic logic [4:0] hex_digit(input logic [7:0] c);
      logic [4:0] r;
      r = 5'h10;
      if (c >= 8'h30 && c <= 8'h39) r = {1'b0, 4'(c - 8'h30)};
      else if (c >= 8'h61 && c <= 8'h66) r = {1'b0, 4'(c - 8'h57)};
      else if (c >= 8'h41 && c <= 8'h46) r = {1'b0, 4'(c - 8'h37)};
      return r;
   endfunction

   // address bytes of a record type
   function automatic logic [2:0] address_bytes(input logic [3:0] rtype);
      logic [2:0] r;
      case (rtype)
         4'd2, 4'd8: r = 3'd3;
         4'd3, 4'd7: r = 3'd4;
         default:    r = 3'd2;
      endcase
      return r;
   endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/s_record_stream_loader.sv =====
// S-record stream loader: character parser and two-entry response buffer.
// Depends on srl_pkg.
`default_nettype none

// Takes one character of S-record text per cycle on the req_ channel and issues a byte
// write per data byte of S1/S2/S3 records on the rsp_ channel; an end-of-input word
// (req_tuser = 1) returns the load report with status and the S7/S8/S9 start address.
// Each word is parsed in the cycle it is accepted and its result lands in a two-entry
// output buffer, so the loader sustains one word per clock; req_tready falls only
// when both buffer entries hold words the consumer has not taken. Checksums are not
// verified; a parse error halts loading until reset, and further end-of-input words
// repeat the report.
module s_record_stream_loader
   import srl_pkg::*;
(
   input  wire                         clock,
   input  wire                         reset,
   input  wire                         req_tvalid,
   output logic                        req_tready,
   input  wire  [7:0]                  req_tdata,  // [7:0] ch
   input  wire  [0:0]                  req_tuser,  // [0] cmd
   output logic                        rsp_tvalid,
   input  wire                         rsp_tready,
   output logic [RSP_TDATA_W-1:0]      rsp_tdata,  // word_address, byte_mask,
                                                   // write_data, status,
                                                   // start_address, zero pad
   output logic [0:0]                  rsp_tuser   // [0] kind
);

   logic [POS_W-1:0] pos_ff, pos_in;
   logic [1:0]       mode_ff, mode_in;
   logic [3:0]       rtype_ff, rtype_in;
   logic [7:0]       count_ff, count_in;
   logic [3:0]       nibble_ff, nibble_in;
   logic [31:0]      acc_ff, acc_in;
   logic [7:0]       done_ff, done_in;
   logic [31:0]      start_ff, start_in;
   logic             halted_ff, halted_in;
   logic [1:0]       status_ff, status_in;

   logic             out_valid_ff, skid_valid_ff;
   rsp_fields_type   out_data_ff, skid_data_ff;
   logic             out_kind_ff, skid_kind_ff;

   logic             accept, pop;
   logic             res_valid;
   logic             res_kind;
   rsp_fields_type   res;

   assign accept     = req_tvalid && req_tready;
   assign pop        = rsp_tvalid && rsp_tready;
   assign req_tready = !skid_valid_ff;

   always_comb begin
      logic [7:0]       ch;
      logic             is_load;
      logic [2:0]       alen;
      logic [POS_W-1:0] rel;
      logic [POS_W-2:0] b;
      logic [4:0]       d;
      logic [7:0]       v;
      logic [31:0]      acc_new;
      logic [7:0]       done_new;
      logic [7:0]       alen_p1;
      logic [POS_W-1:0] pos_next;
      logic             step;

      ch       = req_tdata;
      is_load  = rtype_ff <= 4'd3;
      alen     = address_bytes(rtype_ff);
      alen_p1  = 8'(alen) + 8'd1;
      rel      = pos_ff - POS_W'(2);
      b        = rel[POS_W-1:1];
      d        = hex_digit(ch);
      v        = {nibble_ff, d[3:0]};
      acc_new  = {acc_ff[23:0], v};
      done_new = (done_ff == 8'hff) ? done_ff : done_ff + 8'd1;
      pos_next = pos_ff + POS_W'(1);
      step     = 1'b0;

      pos_in    = pos_ff;
      mode_in   = mode_ff;
      rtype_in  = rtype_ff;
      count_in  = count_ff;
      nibble_in = nibble_ff;
      acc_in    = acc_ff;
      done_in   = done_ff;
      start_in  = start_ff;
      halted_in = halted_ff;
      status_in = status_ff;

      res_valid = 1'b0;
      res_kind  = KIND_WRITE;
      res       = '0;

      if (accept) begin
         if (req_tuser[0] == CMD_END) begin
            if (!halted_ff) begin
               if (mode_ff == MODE_ACTIVE) begin
                  if (pos_ff == POS_W'(1)) begin
                     status_in = STATUS_BAD_TYPE;
                     mode_in   = MODE_SKIP;
                  end else if (is_load) begin
                     status_in = STATUS_BAD_LINE;
                     mode_in   = MODE_SKIP;
                  end else begin
                     start_in = 32'd1;
                  end
               end
               halted_in = 1'b1;
            end
            res_valid         = 1'b1;
            res_kind          = KIND_REPORT;
            res.status        = status_in;
            res.start_address = start_in;
         end else if (!halted_ff) begin
            if (mode_ff == MODE_ACTIVE && pos_ff == POS_W'(1)) begin
               if ((ch >= 8'h31 && ch <= 8'h33) || (ch >= 8'h37 && ch <= 8'h39) ||
                   ch == 8'h30 || (ch >= 8'h34 && ch <= 8'h36)) begin
                  if (ch == 8'h30 || (ch >= 8'h34 && ch <= 8'h36)) begin
                     mode_in = MODE_SKIP;
                  end else begin
                     rtype_in = ch[3:0];
                  end
                  acc_in    = '0;
                  done_in   = '0;
                  nibble_in = '0;
                  count_in  = '0;
                  step      = 1'b1;
               end else begin
                  halted_in = 1'b1;
                  status_in = STATUS_BAD_TYPE;
                  mode_in   = MODE_SKIP;
               end
            end else if (ch == CH_NL) begin
               if (mode_ff == MODE_ACTIVE && is_load) begin
                  halted_in = 1'b1;
                  status_in = STATUS_BAD_LINE;
                  mode_in   = MODE_SKIP;
               end else begin
                  if (mode_ff == MODE_ACTIVE) begin
                     start_in = 32'd1;
                  end
                  pos_in  = '0;
                  mode_in = MODE_START;
               end
            end else if (mode_ff == MODE_START) begin
               mode_in = (ch == CH_S) ? MODE_ACTIVE : MODE_SKIP;
               step    = 1'b1;
            end else if (mode_ff == MODE_ACTIVE) begin
               step = 1'b1;
               if (!is_load && b == '0) begin
                  // count byte of S7-S9 is not inspected
               end else if (d[4]) begin
                  if (is_load) begin
                     halted_in = 1'b1;
                     status_in = STATUS_BAD_LINE;
                     mode_in   = MODE_SKIP;
                     step      = 1'b0;
                  end else begin
                     start_in = 32'd1;
                     mode_in  = MODE_SKIP;
                  end
               end else if (!rel[0]) begin
                  nibble_in = d[3:0];
               end else if (b == '0) begin
                  count_in = v;
               end else if (b <= (POS_W-1)'(alen)) begin
                  acc_in = acc_new;
                  if (b == (POS_W-1)'(alen)) begin
                     if (!is_load) begin
                        start_in = acc_new;
                        mode_in  = MODE_SKIP;
                     end else if (count_ff == alen_p1) begin
                        mode_in = MODE_SKIP;
                     end
                  end
               end else begin
                  res_valid        = 1'b1;
                  res.word_address = acc_ff[31:2];
                  res.byte_mask    = 4'b0001 << acc_ff[1:0];
                  res.write_data   = {24'd0, v} << {acc_ff[1:0], 3'd0};
                  acc_in           = acc_ff + 32'd1;
                  done_in          = done_new;
                  if (count_ff >= alen_p1 && done_new == count_ff - alen_p1) begin
                     mode_in = MODE_SKIP;
                  end
               end
            end else begin
               step = 1'b1;
            end

            if (step) begin
               pos_in = pos_next;
               if (pos_next >= POS_W'(LINE_LIMIT)) begin
                  if (mode_in == MODE_ACTIVE && is_load) begin
                     halted_in = 1'b1;
                     status_in = STATUS_BAD_LINE;
                     mode_in   = MODE_SKIP;
                  end else begin
                     if (mode_in == MODE_ACTIVE) begin
                        start_in = 32'd1;
                     end
                     pos_in  = '0;
                     mode_in = MODE_START;
                  end
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff    <= '0;
         mode_ff   <= MODE_START;
         rtype_ff  <= '0;
         count_ff  <= '0;
         nibble_ff <= '0;
         acc_ff    <= '0;
         done_ff   <= '0;
         start_ff  <= '0;
         halted_ff <= 1'b0;
         status_ff <= STATUS_OK;
      end else begin
         pos_ff    <= pos_in;
         mode_ff   <= mode_in;
         rtype_ff  <= rtype_in;
         count_ff  <= count_in;
         nibble_ff <= nibble_in;
         acc_ff    <= acc_in;
         done_ff   <= done_in;
         start_ff  <= start_in;
         halted_ff <= halted_in;
         status_ff <= status_in;
      end
   end

   // output register plus skid entry
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (skid_valid_ff) begin
         if (pop) begin
            out_valid_ff  <= 1'b1;
            skid_valid_ff <= 1'b0;
         end
      end else if (!out_valid_ff || pop) begin
         out_valid_ff <= res_valid;
      end else if (res_valid) begin
         skid_valid_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (skid_valid_ff) begin
         if (pop) begin
            out_data_ff <= skid_data_ff;
            out_kind_ff <= skid_kind_ff;
         end
      end else if (!out_valid_ff || pop) begin
         out_data_ff <= res;
         out_kind_ff <= res_kind;
      end else begin
         skid_data_ff <= res;
         skid_kind_ff <= res_kind;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {(RSP_TDATA_W - RSP_BITS)'(0), out_data_ff};
   assign rsp_tuser  = out_kind_ff;

endmodule

`default_nettype wire

// ===== hw/rtl/srl_checker.sv =====
// Port-level checker for s_record_stream_loader, bound into s_record_stream_loader.
// Depends on srl_pkg and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module srl_checker
   import srl_pkg::*;
(
   input wire                    clock,
   input wire                    reset,
   input wire                    req_tvalid,
   input wire                    req_tready,
   input wire [0:0]              req_tuser,
   input wire                    rsp_tvalid,
   input wire                    rsp_tready,
   input wire [RSP_TDATA_W-1:0]  rsp_tdata,
   input wire [0:0]              rsp_tuser
);

   logic [3:0]           mask;
   logic [1:0]           status;
   logic [31:0]          start;
   logic [31:0]          wdata;
   logic [RSP_TDATA_W:0] rsp_word;
   logic                 stall;
   logic                 is_write;
   logic                 is_report;
   logic                 write_ok;
   logic                 report_ok;
   logic                 end_in;

   assign mask   = rsp_tdata[RSP_MASK_LO +: 4];
   assign status = rsp_tdata[RSP_STATUS_LO +: 2];
   assign start  = rsp_tdata[RSP_START_LO +: 32];
   assign wdata  = rsp_tdata[RSP_DATA_LO +: 32];

   assign rsp_word  = {rsp_tuser, rsp_tdata};
   assign stall     = rsp_tvalid && !rsp_tready;
   assign is_write  = rsp_tvalid && rsp_tuser[0] == KIND_WRITE;
   assign is_report = rsp_tvalid && rsp_tuser[0] == KIND_REPORT;
   assign write_ok  = $onehot(mask) && status == STATUS_OK && start == 32'd0;
   assign report_ok = mask == 4'd0 && wdata == 32'd0 &&
                      (status == STATUS_OK || status == STATUS_BAD_LINE ||
                       status == STATUS_BAD_TYPE);
   assign end_in    = req_tvalid && req_tready && req_tuser[0] == CMD_END;

   `SRL_ASSERT_ALWAYS(a_idle_after_reset, reset |=> !rsp_tvalid, "rsp valid after reset")

   `SRL_ASSERT(a_rsp_hold, stall |=> rsp_tvalid && $stable(rsp_word), "stalled response changed")

   `SRL_ASSERT(a_write_shape, is_write |-> write_ok, "malformed byte write")

   `SRL_ASSERT(a_report_shape, is_report |-> report_ok, "malformed report")

   `SRL_ASSERT(a_end_reports, end_in |=> rsp_tvalid, "no report after end of input")

endmodule

bind s_record_stream_loader srl_checker u_srl_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .req_tuser  (req_tuser),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);

`default_nettype wire
